// ===== rtl/nfsa_pkg.sv =====
package nfsa_pkg;

  // Fixed field widths
  localparam int REQ_W     = 10;
  localparam int GRANT_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_RESET = 1024;

  // Bitmap organization: one word of slots per memory row
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  typedef enum logic [1:0] {
    AS_GRANTED = 2'd0,
    AS_FULL    = 2'd1,
    AS_RANGE   = 2'd2
  } alloc_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_DN,
    S_UP,
    S_PICK,
    S_WR,
    S_DONE
  } fsm_state_t;

  // Result of one word search
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } find_res_t;

endpackage

// ===== rtl/nfsa_bitmap.sv =====
module nfsa_bitmap import nfsa_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // Write one row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nfsa_find.sv =====
module nfsa_find import nfsa_pkg::*; (
  input  logic [WORD_W-1:0] occ,
  input  logic [WORD_W-1:0] mask,
  input  logic              dir_up,
  output find_res_t         res
);

  logic [WORD_W-1:0] cand;

  assign cand = ~occ & mask;

  // Priority encode: lowest free bit going up, highest free bit going down
  always_comb begin
    res.found = |cand;
    res.pos   = '0;
    if (dir_up) begin
      for (int i = WORD_W - 1; i >= 0; i--) begin
        if (cand[i]) begin
          res.pos = BIT_W'(i);
        end
      end
    end else begin
      for (int i = 0; i < WORD_W; i++) begin
        if (cand[i]) begin
          res.pos = BIT_W'(i);
        end
      end
    end
  end

endmodule

// ===== rtl/nearest_free_slot_allocator.sv =====
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  in_req_slot
// out      output     out_valid/out_ready out_granted_slot, out_alloc_status
// cfg      input      cfg_valid/cfg_ready cfg_slots_in_use
//
// A free requested slot is granted from the first bitmap read, an out-of-range request
// without any bitmap read; otherwise a search scans the NWORDS = ceil(MAX_SLOTS/32), min 2,
// words through the bitmap read port, one 32-slot word a cycle, down then up.
// After reset a clearing pass writes NWORDS rows with in_ready low; cfg_ready stays high
// throughout.
// A stalled result sits in the output register while the next request is taken.
module nearest_free_slot_allocator import nfsa_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   in_req_slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [GRANT_W-1:0] out_granted_slot,
  output logic [1:0]         out_alloc_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_slots_in_use
);

  localparam int NWORDS_RAW = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int NWORDS     = (NWORDS_RAW < 2) ? 2 : NWORDS_RAW;
  localparam int WA_W       = $clog2(NWORDS);
  localparam int SW         = WA_W + BIT_W;
  localparam int N_W        = SW + 1;
  localparam int CNT_W      = (N_W > CFG_W) ? N_W : CFG_W;

  // Configuration register
  logic [CFG_W-1:0] cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(CFG_RESET);
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_slots_in_use;
    end
  end

  // Effective slot count, saturated to the capacity
  logic [CNT_W-1:0] cfg_ext;
  logic [CNT_W-1:0] max_ext;
  logic [CNT_W-1:0] n_full;
  logic [N_W-1:0]   n_eff;
  logic [SW-1:0]    last_slot;
  logic [SW-1:0]    req_s;
  logic             req_range;

  assign cfg_ext   = CNT_W'(cfg_r);
  assign max_ext   = CNT_W'(MAX_SLOTS);
  assign n_full    = (cfg_ext > max_ext) ? max_ext : cfg_ext;
  assign n_eff     = N_W'(n_full);
  assign last_slot = SW'(n_eff - N_W'(1));
  assign req_s     = SW'(in_req_slot);
  assign req_range = (CNT_W'(in_req_slot) >= n_full);

  // Sequencer state
  fsm_state_t    state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [WA_W-1:0] ptr_r, ptr_nxt;
  logic [SW-1:0] x_r, x_nxt;
  logic [SW-1:0] last_r, last_nxt;
  logic [SW-1:0] lo_r, lo_nxt;
  logic [SW-1:0] hi_r, hi_nxt;
  logic          have_lo_r, have_lo_nxt;
  logic          have_hi_r, have_hi_nxt;
  logic [SW-1:0] grant_r, grant_nxt;
  alloc_status_t status_r, status_nxt;
  logic [SW-1:0] out_grant_r, out_grant_nxt;
  alloc_status_t out_status_r, out_status_nxt;

  // Bitmap and finder hookup
  logic              bm_we;
  logic [WA_W-1:0]   bm_waddr;
  logic [WORD_W-1:0] bm_wdata;
  logic              bm_re;
  logic [WA_W-1:0]   bm_raddr;
  logic [WORD_W-1:0] bm_rdata;
  logic [WORD_W-1:0] fd_mask;
  logic              fd_up;
  find_res_t         fd_res;

  nfsa_bitmap #(
    .DEPTH (NWORDS),
    .AW    (WA_W)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  nfsa_find u_find (
    .occ    (bm_rdata),
    .mask   (fd_mask),
    .dir_up (fd_up),
    .res    (fd_res)
  );

  // Word and bit split of the request and the last slot
  logic [WA_W-1:0]   xw, lw;
  logic [BIT_W-1:0]  xb, lb;
  logic [WORD_W-1:0] ones;
  logic [WORD_W-1:0] below_x, above_x, upto_last;
  logic [SW-1:0]     d_lo, d_hi;
  logic [SW-1:0]     pick;

  assign xw        = x_r[SW-1:BIT_W];
  assign xb        = x_r[BIT_W-1:0];
  assign lw        = last_r[SW-1:BIT_W];
  assign lb        = last_r[BIT_W-1:0];
  assign ones      = '1;
  assign below_x   = ~(ones << xb);
  assign above_x   = (ones << xb) << 1;
  assign upto_last = ~((ones << lb) << 1);
  assign d_lo      = x_r - lo_r;
  assign d_hi      = hi_r - x_r;
  assign pick      = (have_lo_r && (!have_hi_r || d_lo <= d_hi)) ? lo_r : hi_r;

  // Next state, bitmap access and finder control
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ptr_nxt        = ptr_r;
    x_nxt          = x_r;
    last_nxt       = last_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    have_lo_nxt    = have_lo_r;
    have_hi_nxt    = have_hi_r;
    grant_nxt      = grant_r;
    status_nxt     = status_r;
    out_grant_nxt  = out_grant_r;
    out_status_nxt = out_status_r;
    bm_we          = 1'b0;
    bm_waddr       = ptr_r;
    bm_wdata       = '0;
    bm_re          = 1'b0;
    bm_raddr       = ptr_r;
    fd_mask        = '0;
    fd_up          = 1'b0;
    in_ready       = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // Sweep the bitmap to all free
        bm_we    = 1'b1;
        bm_waddr = ptr_r;
        bm_wdata = '0;
        if (ptr_r == WA_W'(NWORDS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + WA_W'(1);
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_range) begin
            grant_nxt  = '0;
            status_nxt = AS_RANGE;
            state_nxt  = S_DONE;
          end else begin
            x_nxt     = req_s;
            last_nxt  = last_slot;
            ptr_nxt   = req_s[SW-1:BIT_W];
            bm_re     = 1'b1;
            bm_raddr  = req_s[SW-1:BIT_W];
            state_nxt = S_CHK;
          end
        end
      end

      S_CHK: begin
        // Grant the requested slot at once when free
        if (!bm_rdata[xb]) begin
          bm_we      = 1'b1;
          bm_waddr   = xw;
          bm_wdata   = bm_rdata | (WORD_W'(1) << xb);
          grant_nxt  = x_r;
          status_nxt = AS_GRANTED;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_DN;
        end
      end

      S_DN: begin
        // Scan downward one word a cycle
        fd_up   = 1'b0;
        fd_mask = (ptr_r == xw) ? below_x : ones;
        if (fd_res.found || ptr_r == '0) begin
          have_lo_nxt = fd_res.found;
          lo_nxt      = {ptr_r, fd_res.pos};
          ptr_nxt     = xw;
          bm_re       = 1'b1;
          bm_raddr    = xw;
          state_nxt   = S_UP;
        end else begin
          ptr_nxt  = ptr_r - WA_W'(1);
          bm_re    = 1'b1;
          bm_raddr = ptr_r - WA_W'(1);
        end
      end

      S_UP: begin
        // Scan upward one word a cycle, stop at the last slot in use
        fd_up   = 1'b1;
        fd_mask = ((ptr_r == xw) ? above_x : ones) & ((ptr_r == lw) ? upto_last : ones);
        if (fd_res.found || ptr_r == lw) begin
          have_hi_nxt = fd_res.found;
          hi_nxt      = {ptr_r, fd_res.pos};
          state_nxt   = S_PICK;
        end else begin
          ptr_nxt  = ptr_r + WA_W'(1);
          bm_re    = 1'b1;
          bm_raddr = ptr_r + WA_W'(1);
        end
      end

      S_PICK: begin
        // Take the closer side, lower on a tie
        if (have_lo_r || have_hi_r) begin
          grant_nxt  = pick;
          status_nxt = AS_GRANTED;
          bm_re      = 1'b1;
          bm_raddr   = pick[SW-1:BIT_W];
          state_nxt  = S_WR;
        end else begin
          grant_nxt  = '0;
          status_nxt = AS_FULL;
          state_nxt  = S_DONE;
        end
      end

      S_WR: begin
        // Mark the granted slot occupied
        bm_we     = 1'b1;
        bm_waddr  = grant_r[SW-1:BIT_W];
        bm_wdata  = bm_rdata | (WORD_W'(1) << grant_r[BIT_W-1:0]);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_grant_nxt  = grant_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    last_r       <= last_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    have_lo_r    <= have_lo_nxt;
    have_hi_r    <= have_hi_nxt;
    grant_r      <= grant_nxt;
    status_r     <= status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = GRANT_W'(out_grant_r);
  assign out_alloc_status = out_status_r;

endmodule

// ===== rtl/nfsa_checker.sv =====
module nfsa_checker import nfsa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [GRANT_W-1:0] out_granted_slot,
  input logic [1:0]         out_alloc_status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_slot)
      && $stable(out_alloc_status))
    else $error("result changed while stalled");

  // Report only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alloc_status == AS_GRANTED || out_alloc_status == AS_FULL
      || out_alloc_status == AS_RANGE))
    else $error("undefined status code");

  // Drive slot zero on every refusal
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alloc_status != AS_GRANTED |-> out_granted_slot == '0)
    else $error("refused request carries a slot");

  // Drop ready after each request transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // Come out of reset with no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind nearest_free_slot_allocator nfsa_checker u_nfsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_granted_slot (out_granted_slot),
  .out_alloc_status (out_alloc_status)
);
